// ===== src/smap_pkg.sv =====
// shared types and constants for the strided slice index mapper
package smap_pkg;

	localparam int unsigned IDX_W  = 33;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned WIDE_W = 36;
	localparam int unsigned POS_W  = 43;
	localparam int unsigned CNT_W  = 6;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ZERO_STEP  = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_START_OUT  = 3'd3;
	localparam logic [2:0] ST_MINMAX_OUT = 3'd4;
	localparam logic [2:0] ST_ABOVE_MAX  = 3'd5;
	localparam logic [2:0] ST_BELOW_MIN  = 3'd6;

	localparam logic [2:0] REG_VECTOR_SIZE   = 3'd0;
	localparam logic [2:0] REG_SLICE_MODE    = 3'd1;
	localparam logic [2:0] REG_SLICE_START   = 3'd2;
	localparam logic [2:0] REG_SLICE_STOP    = 3'd3;
	localparam logic [2:0] REG_SLICE_STEP    = 3'd4;
	localparam logic [2:0] REG_START_OMITTED = 3'd5;
	localparam logic [2:0] REG_STOP_OMITTED  = 3'd6;
	localparam logic [2:0] REG_STEP_OMITTED  = 3'd7;

	localparam logic [40:0] PROD_LIMIT = 41'h100_0000_0000;

	typedef enum logic [1:0] {
		BASE_ZERO = 2'd0,
		BASE_LO   = 2'd1,
		BASE_HI   = 2'd2,
		BASE_SIZE = 2'd3
	} base_sel_t;

	typedef enum logic [3:0] {
		SU_IDLE = 4'b0001,
		SU_LOAD = 4'b0010,
		SU_DIV  = 4'b0100,
		SU_FIN  = 4'b1000
	} setup_state_t;

	typedef struct packed {
		logic                     ready;
		logic                     plain;
		logic                     step_neg;
		logic [32:0]              den;
		logic signed [33:0]       lo;
		logic signed [33:0]       hi;
		logic [ADDR_W-1:0]        size;
		logic [ADDR_W-1:0]        len;
		logic [2:0]               err;
	} derived_t;

	typedef struct packed {
		logic [IDX_W-1:0] mag;
		logic             neg;
		base_sel_t        base;
	} work_t;

endpackage

// ===== src/strided_slice_index_mapper_core.sv =====
// top level of the strided slice index mapper
//
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// item in   in         start, busy               logical_index
// item out  out        done strobe, one cycle    element_address, slice_length, status
//
// one item per cycle while busy is low; results pass the queue and back-end registers
// after reset and after every config write busy stays high
// while the slice bounds are derived by the serial divider
// the receiver cannot stall; results are never held
module strided_slice_index_mapper_core #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [32:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [32:0] logical_index,
	output logic               done,
	output logic [31:0]        element_address,
	output logic [31:0]        slice_length,
	output logic [2:0]         status
);
	import smap_pkg::*;

	derived_t drv;
	work_t    entry, head;
	logic     push, full, head_valid, accept;

	assign cfg_ready = 1'b1;
	assign busy      = !drv.ready || full;
	assign accept    = start && !busy;

	smap_setup #(.INDEX_BITS(INDEX_BITS)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.drv       (drv)
	);

	smap_front u_front (
		.accept        (accept),
		.logical_index (logical_index),
		.drv           (drv),
		.push          (push),
		.entry         (entry)
	);

	smap_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.full      (full),
		.pop_valid (head_valid),
		.pop_data  (head)
	);

	smap_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (head_valid),
		.in_data         (head),
		.drv             (drv),
		.done            (done),
		.element_address (element_address),
		.slice_length    (slice_length),
		.status          (status)
	);

endmodule

// ===== src/smap_setup.sv =====
// configuration registers and derivation of slice bounds with a serial divider
module smap_setup #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [32:0]          cfg_data,
	output smap_pkg::derived_t   drv
);
	import smap_pkg::*;

	localparam logic [63:0] MASK64    = (64'd1 << INDEX_BITS) - 64'd1;
	localparam logic [31:0] SIZE_MASK = MASK64[31:0];

	logic [31:0]        vector_size_q;
	logic               slice_mode_q;
	logic [32:0]        slice_start_q;
	logic [32:0]        slice_stop_q;
	logic [32:0]        slice_step_q;
	logic               start_omitted_q;
	logic               stop_omitted_q;
	logic               step_omitted_q;
	logic               dirty_q;
	setup_state_t       state_q;

	logic signed [WIDE_W-1:0] vs, step_e, start_e, stop_e, start_r, stop_c, start_c;
	logic               step_zero, step_pos, step_neg_c, empty_c;
	logic [WIDE_W-1:0]  num_c, nq_c;
	logic [2:0]         err_c;

	logic signed [WIDE_W-1:0] start_q;
	logic [WIDE_W-1:0]  num_q, nq_q;
	logic [32:0]        den_q;
	logic [33:0]        rem_q;
	logic [ADDR_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [2:0]         err_q;
	logic               neg_q;

	logic [33:0]        rem_sh;
	logic               rem_ge;
	logic [WIDE_W-1:0]  span;
	logic signed [WIDE_W-1:0] last, lo_c, hi_c;
	logic               minmax;

	derived_t           drv_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_size_q   <= '0;
			slice_mode_q    <= 1'b0;
			slice_start_q   <= '0;
			slice_stop_q    <= '0;
			slice_step_q    <= 33'd1;
			start_omitted_q <= 1'b1;
			stop_omitted_q  <= 1'b1;
			step_omitted_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VECTOR_SIZE:   vector_size_q   <= cfg_data[31:0];
				REG_SLICE_MODE:    slice_mode_q    <= cfg_data[0];
				REG_SLICE_START:   slice_start_q   <= cfg_data;
				REG_SLICE_STOP:    slice_stop_q    <= cfg_data;
				REG_SLICE_STEP:    slice_step_q    <= cfg_data;
				REG_START_OMITTED: start_omitted_q <= cfg_data[0];
				REG_STOP_OMITTED:  stop_omitted_q  <= cfg_data[0];
				REG_STEP_OMITTED:  step_omitted_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// normalize bounds
	always_comb begin
		vs         = $signed({4'b0, vector_size_q & SIZE_MASK});
		step_zero  = !step_omitted_q && (slice_step_q == '0);
		step_e     = step_omitted_q ? WIDE_W'(1)
		                            : WIDE_W'($signed(slice_step_q));
		step_pos   = !step_zero && !step_e[WIDE_W-1];
		step_neg_c = step_e[WIDE_W-1];
		stop_e     = WIDE_W'($signed(slice_stop_q));
		start_e    = WIDE_W'($signed(slice_start_q));
		if (stop_omitted_q)
			stop_c = step_pos ? vs : -WIDE_W'(1);
		else
			stop_c = stop_e[WIDE_W-1] ? stop_e + vs : stop_e;
		start_r = start_e[WIDE_W-1] ? start_e + vs : start_e;
		if (start_omitted_q)
			start_c = step_pos ? '0 : vs - WIDE_W'(1);
		else
			start_c = start_r;
		empty_c = !((start_c < stop_c && step_pos) || (start_c > stop_c && step_neg_c));
		num_c   = step_neg_c ? WIDE_W'(start_c - stop_c) : WIDE_W'(stop_c - start_c);
		nq_c    = num_c + WIDE_W'(step_e[WIDE_W-1] ? -step_e : step_e) - WIDE_W'(1);
		if (step_zero)
			err_c = ST_ZERO_STEP;
		else if (empty_c)
			err_c = ST_EMPTY;
		else if (start_c >= vs)
			err_c = ST_START_OUT;
		else
			err_c = ST_OK;
	end

	// restoring divide step and bounds from the remainder
	always_comb begin
		rem_sh = {rem_q[32:0], nq_q[WIDE_W-1]};
		rem_ge = rem_sh >= {1'b0, den_q};
		span   = num_q - WIDE_W'(1) - WIDE_W'(rem_q);
		last   = neg_q ? start_q - $signed(span) : start_q + $signed(span);
		lo_c   = (start_q < last) ? start_q : last;
		hi_c   = (start_q < last) ? last : start_q;
		minmax = lo_c[WIDE_W-1] || (lo_c >= vs) || hi_c[WIDE_W-1] || (hi_c >= vs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			dirty_q <= 1'b1;
			drv_q   <= '0;
		end else begin
			if (cfg_valid) begin
				dirty_q     <= 1'b1;
				drv_q.ready <= 1'b0;
			end
			case (state_q)
				SU_IDLE: begin
					if (dirty_q && !cfg_valid) begin
						dirty_q <= 1'b0;
						state_q <= SU_LOAD;
					end
				end
				SU_LOAD: begin
					state_q <= SU_DIV;
				end
				SU_DIV: begin
					if (cnt_q == '0)
						state_q <= SU_FIN;
				end
				SU_FIN: begin
					state_q <= SU_IDLE;
					if (!dirty_q && !cfg_valid)
						drv_q.ready <= 1'b1;
					drv_q.size  <= vs[ADDR_W-1:0];
					drv_q.plain <= !slice_mode_q;
					if (!slice_mode_q) begin
						drv_q.step_neg <= 1'b0;
						drv_q.den      <= 33'd1;
						drv_q.lo       <= '0;
						drv_q.hi       <= 34'(vs - WIDE_W'(1));
						drv_q.len      <= vs[ADDR_W-1:0];
						drv_q.err      <= ST_OK;
					end else begin
						drv_q.step_neg <= neg_q;
						drv_q.den      <= den_q;
						drv_q.lo       <= lo_c[33:0];
						drv_q.hi       <= hi_c[33:0];
						drv_q.len      <= quo_q;
						if (err_q != ST_OK)
							drv_q.err <= err_q;
						else if (minmax)
							drv_q.err <= ST_MINMAX_OUT;
						else
							drv_q.err <= ST_OK;
					end
				end
				default: state_q <= SU_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SU_LOAD: begin
				start_q <= start_c;
				num_q   <= num_c;
				nq_q    <= nq_c;
				den_q   <= step_neg_c ? 33'(-step_e) : step_e[32:0];
				neg_q   <= step_neg_c;
				err_q   <= err_c;
				rem_q   <= '0;
				quo_q   <= '0;
				cnt_q   <= CNT_W'(WIDE_W - 1);
			end
			SU_DIV: begin
				rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[ADDR_W-2:0], rem_ge};
				nq_q  <= {nq_q[WIDE_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign drv = drv_q;

endmodule

// ===== src/smap_front.sv =====
// front end: accepts an item and classifies it for the multiply pipeline
module smap_front (
	input  logic                      accept,
	input  logic signed [32:0]        logical_index,
	input  smap_pkg::derived_t        drv,
	output logic                      push,
	output smap_pkg::work_t           entry
);
	import smap_pkg::*;

	logic signed [33:0] idx_adj;
	logic               idx_neg;

	always_comb begin
		idx_neg = logical_index[32];
		if (drv.plain || !idx_neg)
			idx_adj = 34'(logical_index);
		else
			idx_adj = 34'(logical_index) + 34'sd1;
		entry.mag = idx_adj[33] ? 33'(-idx_adj) : idx_adj[32:0];
		if (drv.plain) begin
			entry.neg  = idx_neg;
			entry.base = idx_neg ? BASE_SIZE : BASE_ZERO;
		end else begin
			entry.neg  = idx_adj[33] ^ drv.step_neg;
			entry.base = (idx_neg ^ drv.step_neg) ? BASE_HI : BASE_LO;
		end
		push = accept;
	end

endmodule

// ===== src/smap_queue.sv =====
// two-entry item queue between front and back
module smap_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  smap_pkg::work_t   push_data,
	output logic              full,
	output logic              pop_valid,
	output smap_pkg::work_t   pop_data
);
	import smap_pkg::*;

	work_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = cnt_q != 2'd0;
	assign pop_valid = pop;
	assign pop_data  = mem_q[rd_q];
	assign full      = cnt_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== src/smap_back.sv =====
// back end: saturating multiply, offset and range check
module smap_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  smap_pkg::work_t           in_data,
	input  smap_pkg::derived_t        drv,
	output logic                      done,
	output logic [31:0]               element_address,
	output logic [31:0]               slice_length,
	output logic [2:0]                status
);
	import smap_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [49:0] pp0_s1;
	logic [48:0] pp1_s1;
	logic        neg_s1, neg_s2;
	base_sel_t   base_s1, base_s2;
	logic signed [41:0]     term_s2;
	logic signed [POS_W-1:0] pos_s3;
	logic [31:0] addr_s4, len_s4;
	logic [2:0]  st_s4;

	logic [65:0] prod;
	logic [40:0] sat;
	logic signed [POS_W-1:0] base_v;
	logic [2:0]  st_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: partial products
	always_ff @(posedge clk) begin
		pp0_s1  <= 50'(in_data.mag) * 50'(drv.den[16:0]);
		pp1_s1  <= 49'(in_data.mag) * 49'(drv.den[32:17]);
		neg_s1  <= in_data.neg;
		base_s1 <= in_data.base;
	end

	// stage 2: sum and saturate
	always_comb begin
		prod = 66'(pp0_s1) + (66'(pp1_s1) << 17);
		sat  = (prod > 66'(PROD_LIMIT)) ? PROD_LIMIT : prod[40:0];
	end

	always_ff @(posedge clk) begin
		term_s2 <= neg_s1 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		base_s2 <= base_s1;
	end

	// stage 3: add base
	always_comb begin
		case (base_s2)
			BASE_ZERO: base_v = '0;
			BASE_LO:   base_v = POS_W'(drv.lo);
			BASE_HI:   base_v = POS_W'(drv.hi);
			BASE_SIZE: base_v = $signed({11'b0, drv.size});
			default:   base_v = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		pos_s3 <= base_v + POS_W'(term_s2);
	end

	// stage 4: classify
	always_comb begin
		if (drv.err != ST_OK)
			st_c = drv.err;
		else if (pos_s3 > POS_W'(drv.hi))
			st_c = ST_ABOVE_MAX;
		else if (pos_s3 < POS_W'(drv.lo))
			st_c = drv.plain ? ST_ABOVE_MAX : ST_BELOW_MIN;
		else
			st_c = ST_OK;
	end

	always_ff @(posedge clk) begin
		st_s4   <= st_c;
		addr_s4 <= (st_c == ST_OK) ? pos_s3[31:0] : '0;
		len_s4  <= (drv.err == ST_OK) ? drv.len : '0;
	end

	assign done            = v_s4;
	assign element_address = addr_s4;
	assign slice_length    = len_s4;
	assign status          = st_s4;

endmodule
